FILE: src/assert_macros.svh
// Assertion helpers for the checker module in bfkn_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BFKN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BFKN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/bfkn_pkg.sv
`timescale 1ns / 1ps

package bfkn_pkg;

  localparam int POOL_DEPTH     = 256;
  localparam int MAX_DIMS       = 16;
  localparam int MAX_NEIGHBOURS = 8;

  localparam int VEC_W   = $clog2(POOL_DEPTH);
  localparam int DIM_W   = $clog2(MAX_DIMS);
  localparam int RANK_W  = $clog2(MAX_NEIGHBOURS);
  localparam int POOL_WORDS = POOL_DEPTH * MAX_DIMS;
  localparam int POOL_AW = $clog2(POOL_WORDS);

  localparam int COMP_W  = 16;
  localparam int DIST_W  = 38;
  localparam int SQ_W    = 2 * COMP_W;

  localparam int DIMS_CFG_W = 5;
  localparam int NVEC_CFG_W = 9;
  localparam int K_CFG_W    = 4;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_DIMS_IN_USE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VECTORS_IN_USE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOURS_IN_USE = 2'd2;

  // Request kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef struct packed {
    logic              req_type;
    logic [7:0]        vector_index;
    logic [3:0]        component_index;
    logic signed [15:0] component_value;
  } bfkn_in_t;

  typedef struct packed {
    logic [2:0]        rank;
    logic [7:0]        neighbour_index;
    logic [DIST_W-1:0] distance;
    logic              found;
    logic              last;
  } bfkn_out_t;

  // One slot of the best-k list
  typedef struct packed {
    logic              valid;
    logic [VEC_W-1:0]  idx;
    logic [DIST_W-1:0] dist_sq;
  } bfkn_entry_t;

  localparam bfkn_entry_t EMPTY_ENTRY = '{valid: 1'b0, idx: '0, dist_sq: DIST_MAX};

  // Controls broadcast to every list cell
  typedef struct packed {
    logic clear;
    logic insert;
    logic shift_up;
  } bfkn_cell_ctl_t;

  // Sideband that travels with one component through the distance pipe
  typedef struct packed {
    logic             vld;
    logic             first;
    logic             last;
    logic [VEC_W-1:0] idx;
  } bfkn_tag_t;

endpackage

FILE: src/bfkn_ram.sv
`timescale 1ns / 1ps

module bfkn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/bfkn_dist.sv
`timescale 1ns / 1ps

module bfkn_dist import bfkn_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  bfkn_tag_t          tag_in,
  input  logic [COMP_W-1:0]  pool_val,
  input  logic [COMP_W-1:0]  qry_val,
  output bfkn_entry_t        cand,
  output logic               cand_vld,
  output logic               busy
);

  bfkn_tag_t         tag_a_r, tag_b_r;
  logic [COMP_W-1:0] abs_r;
  logic [SQ_W-1:0]   sq_r;
  logic [DIST_W-1:0] acc_r, acc_nxt;
  logic              cand_vld_r;
  bfkn_entry_t       cand_r;
  logic signed [COMP_W:0] diff;

  // difference of two signed components, magnitude fits COMP_W bits
  assign diff = $signed({pool_val[COMP_W-1], pool_val}) - $signed({qry_val[COMP_W-1], qry_val});
  assign acc_nxt = (tag_b_r.first ? '0 : acc_r) + DIST_W'(sq_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_a_r    <= '0;
      tag_b_r    <= '0;
      cand_vld_r <= 1'b0;
    end else begin
      tag_a_r    <= tag_in;
      tag_b_r    <= tag_a_r;
      cand_vld_r <= tag_b_r.vld && tag_b_r.last;
    end
  end

  always_ff @(posedge clk) begin
    abs_r <= diff[COMP_W] ? COMP_W'(-diff) : diff[COMP_W-1:0];
    sq_r  <= abs_r * abs_r;
    if (tag_b_r.vld) begin
      acc_r <= acc_nxt;
      if (tag_b_r.last) begin
        cand_r <= '{valid: 1'b1, idx: tag_b_r.idx, dist_sq: acc_nxt};
      end
    end
  end

  assign cand     = cand_r;
  assign cand_vld = cand_vld_r;
  assign busy     = tag_a_r.vld || tag_b_r.vld || cand_vld_r;

endmodule

FILE: src/bfkn_cell.sv
`timescale 1ns / 1ps

module bfkn_cell import bfkn_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  bfkn_cell_ctl_t ctl,
  input  bfkn_entry_t    cand,
  input  bfkn_entry_t    upper,
  input  logic           upper_take,
  input  bfkn_entry_t    lower,
  output bfkn_entry_t    ent,
  output logic           take
);

  bfkn_entry_t ent_r, ent_nxt;

  // strictly closer or slot empty: ties leave the earlier vector in place
  assign take = ctl.insert && (!ent_r.valid || ent_r.dist_sq > cand.dist_sq);

  always_comb begin
    ent_nxt = ent_r;
    priority if (ctl.clear) begin
      ent_nxt = EMPTY_ENTRY;
    end else if (ctl.shift_up) begin
      ent_nxt = lower;
    end else if (upper_take) begin
      ent_nxt = upper;
    end else if (take) begin
      ent_nxt = cand;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= EMPTY_ENTRY;
    end else begin
      ent_r <= ent_nxt;
    end
  end

  assign ent = ent_r;

endmodule

FILE: src/brute_force_k_nearest_top.sv
`timescale 1ns / 1ps

// Brute-force k-nearest-neighbor search. Load words write one 16-bit signed
// component of one pool vector into a 4096-word RAM; query words write one
// component of the query point. Both may stream back to back. The query word
// whose component index is dims_in_use-1 starts a search: the block reads the
// pool RAM one component a cycle (the single RAM read port sets this rate),
// then drains the distance pipe. Each finished distance drops into a sorted
// row of MAX_NEIGHBOURS cells that register it in its sorted place; ties keep
// the earlier vector. Then neighbours_in_use result words leave in rank order,
// one a cycle while out_ready is high. in_ready is low from the starting query
// word until the last result word has been loaded into the output register.
// Unused ranks report found = 0, index 0 and the all-ones distance. Write
// configuration only while the block is idle.
module brute_force_k_nearest_top import bfkn_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bfkn_in_t              in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bfkn_out_t             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0] state_r, state_nxt;

  // configuration registers and their saturated views
  logic [DIMS_CFG_W-1:0] dims_r;
  logic [NVEC_CFG_W-1:0] nvec_r;
  logic [K_CFG_W-1:0]    k_r;
  logic [DIMS_CFG_W-1:0] dims_eff;
  logic [NVEC_CFG_W-1:0] nvec_eff;
  logic [K_CFG_W-1:0]    k_eff;
  logic [DIM_W-1:0]      dims_last;
  logic [RANK_W-1:0]     k_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= DIMS_CFG_W'(MAX_DIMS);
      nvec_r <= NVEC_CFG_W'(POOL_DEPTH);
      k_r    <= K_CFG_W'(MAX_NEIGHBOURS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIMS_IN_USE:       dims_r <= cfg_wdata[DIMS_CFG_W-1:0];
        CFG_VECTORS_IN_USE:    nvec_r <= cfg_wdata[NVEC_CFG_W-1:0];
        CFG_NEIGHBOURS_IN_USE: k_r    <= cfg_wdata[K_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp into the supported ranges; zero vectors scans nothing
  always_comb begin
    if (dims_r == '0) dims_eff = DIMS_CFG_W'(1);
    else if (dims_r > DIMS_CFG_W'(MAX_DIMS)) dims_eff = DIMS_CFG_W'(MAX_DIMS);
    else dims_eff = dims_r;
    if (nvec_r > NVEC_CFG_W'(POOL_DEPTH)) nvec_eff = NVEC_CFG_W'(POOL_DEPTH);
    else nvec_eff = nvec_r;
    if (k_r == '0) k_eff = K_CFG_W'(1);
    else if (k_r > K_CFG_W'(MAX_NEIGHBOURS)) k_eff = K_CFG_W'(MAX_NEIGHBOURS);
    else k_eff = k_r;
  end

  assign dims_last = DIM_W'(dims_eff - DIMS_CFG_W'(1));
  assign k_last    = RANK_W'(k_eff - K_CFG_W'(1));

  // input side: loads go to the pool RAM, query components to the query row
  logic in_acc, load_we, qry_we, start;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign load_we  = in_acc && (in_word.req_type == REQ_LOAD)
                    && (32'(in_word.vector_index) < POOL_DEPTH)
                    && (32'(in_word.component_index) < MAX_DIMS);
  assign qry_we   = in_acc && (in_word.req_type == REQ_QUERY)
                    && (32'(in_word.component_index) < MAX_DIMS);
  assign start    = qry_we && (in_word.component_index == dims_last);

  logic [COMP_W-1:0] qp_r [MAX_DIMS];

  always_ff @(posedge clk) begin
    if (qry_we) begin
      qp_r[in_word.component_index[DIM_W-1:0]] <= in_word.component_value;
    end
  end

  // scan sequencer: one pool component per cycle
  logic [VEC_W-1:0] vec_cnt_r, vec_cnt_nxt;
  logic [DIM_W-1:0] dim_cnt_r, dim_cnt_nxt;
  logic             issue, dim_wrap, vec_done;
  bfkn_tag_t        tag_s0, tag_s1_r;
  logic [COMP_W-1:0] qp_s1_r;
  logic [COMP_W-1:0] pool_rdata;

  assign issue    = (state_r == ST_SCAN);
  assign dim_wrap = (dim_cnt_r == dims_last);
  assign vec_done = ({1'b0, vec_cnt_r} == nvec_eff - NVEC_CFG_W'(1));

  assign tag_s0 = '{vld: issue, first: (dim_cnt_r == '0), last: dim_wrap, idx: vec_cnt_r};

  bfkn_ram #(
    .WIDTH (COMP_W),
    .DEPTH (POOL_WORDS)
  ) u_pool (
    .clk   (clk),
    .we    (load_we),
    .waddr (POOL_AW'({in_word.vector_index, in_word.component_index})),
    .wdata (in_word.component_value),
    .re    (issue),
    .raddr ({vec_cnt_r, dim_cnt_r}),
    .rdata (pool_rdata)
  );

  // hold the query component next to the RAM read so both land together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_s1_r <= '0;
    end else begin
      tag_s1_r <= tag_s0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      qp_s1_r <= qp_r[dim_cnt_r];
    end
  end

  bfkn_entry_t cand;
  logic        cand_vld, dist_busy;

  bfkn_dist u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .tag_in   (tag_s1_r),
    .pool_val (pool_rdata),
    .qry_val  (qp_s1_r),
    .cand     (cand),
    .cand_vld (cand_vld),
    .busy     (dist_busy)
  );

  // result side
  logic [RANK_W-1:0] rank_r, rank_nxt;
  logic              out_valid_r;
  bfkn_out_t         out_word_r;
  logic              emit_load;

  // sorted row of cells; rank 0 sits in cell 0
  bfkn_cell_ctl_t cell_ctl;
  bfkn_entry_t    ent  [MAX_NEIGHBOURS];
  logic           take [MAX_NEIGHBOURS];

  assign emit_load = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign cell_ctl  = '{clear: start, insert: cand_vld, shift_up: emit_load};

  for (genvar gi = 0; gi < MAX_NEIGHBOURS; gi++) begin : g_cell
    bfkn_entry_t up_ent, lo_ent;
    logic        up_take;

    if (gi == 0) begin : g_head
      assign up_ent  = EMPTY_ENTRY;
      assign up_take = 1'b0;
    end else begin : g_body
      assign up_ent  = ent[gi-1];
      assign up_take = take[gi-1];
    end

    if (gi == MAX_NEIGHBOURS - 1) begin : g_tail
      assign lo_ent = EMPTY_ENTRY;
    end else begin : g_mid
      assign lo_ent = ent[gi+1];
    end

    bfkn_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (cell_ctl),
      .cand       (cand),
      .upper      (up_ent),
      .upper_take (up_take),
      .lower      (lo_ent),
      .ent        (ent[gi]),
      .take       (take[gi])
    );
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    vec_cnt_nxt = vec_cnt_r;
    dim_cnt_nxt = dim_cnt_r;
    rank_nxt    = rank_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          vec_cnt_nxt = '0;
          dim_cnt_nxt = '0;
          state_nxt   = (nvec_eff == '0) ? ST_DRAIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (dim_wrap) begin
          dim_cnt_nxt = '0;
          if (vec_done) begin
            state_nxt = ST_DRAIN;
          end else begin
            vec_cnt_nxt = vec_cnt_r + VEC_W'(1);
          end
        end else begin
          dim_cnt_nxt = dim_cnt_r + DIM_W'(1);
        end
      end
      ST_DRAIN: begin
        // wait until the last distance has been inserted
        if (!tag_s1_r.vld && !dist_busy) begin
          rank_nxt  = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_load) begin
          rank_nxt = rank_r + RANK_W'(1);
          if (rank_r == k_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      vec_cnt_r <= '0;
      dim_cnt_r <= '0;
      rank_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      vec_cnt_r <= vec_cnt_nxt;
      dim_cnt_r <= dim_cnt_nxt;
      rank_r    <= rank_nxt;
    end
  end

  // output register: advance on load, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_word_r <= '{rank:            3'(rank_r),
                      neighbour_index: 8'(ent[0].idx),
                      distance:        ent[0].dist_sq,
                      found:           ent[0].valid,
                      last:            (rank_r == k_last)};
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

FILE: src/bfkn_chk.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bfkn_chk import bfkn_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input bfkn_out_t out_word
);

  logic out_stall, out_more;

  assign out_stall = out_valid && !out_ready;
  assign out_more  = out_valid && out_ready && !out_word.last;

  `BFKN_ASSERT_NXT(a_out_hold, out_stall, out_valid && $stable(out_word), "result word dropped or changed while stalled")
  `BFKN_ASSERT_IMP(a_empty_slot, out_valid && !out_word.found, (out_word.neighbour_index == '0) && (out_word.distance == DIST_MAX), "empty slot carries index or distance")
  `BFKN_ASSERT_NXT(a_rank_step, out_more, out_valid && (out_word.rank == $past(out_word.rank) + 3'd1), "result ranks not consecutive")
  `BFKN_ASSERT_IMP(a_busy_emit, out_more, !in_ready, "input taken while a query still emits")

endmodule

bind brute_force_k_nearest_top bfkn_chk u_bfkn_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

FILE: tb/sv/brute_force_k_nearest_top_test.sv
`timescale 1ns / 1ps

module brute_force_k_nearest_top_test;
  import bfkn_pkg::*;

  localparam int SETTLE_CYCLES  = 20;    // distance pipe drain plus margin
  localparam int LONG_HOLD      = 300;   // receiver hold-off that backs up the block
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no word moving on either side

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;  // unmapped register index

  localparam logic [COMP_W-1:0] COMP_MIN  = 16'h8000;
  localparam logic [COMP_W-1:0] COMP_MAX  = 16'h7FFF;
  localparam logic [COMP_W-1:0] COMP_ZERO = 16'h0000;
  localparam logic [COMP_W-1:0] COMP_ONES = 16'hFFFF;

  // Predicts the ranked neighbor list of every search and checks the result words
  // against it in order. Tracks which pool and query components were written so
  // the stimulus never starts a search that reads an unwritten entry.
  class knn_checker;
    logic [COMP_W-1:0]     pool_mem  [POOL_DEPTH][MAX_DIMS];
    bit                    pool_set  [POOL_DEPTH][MAX_DIMS];
    logic [COMP_W-1:0]     query_pt  [MAX_DIMS];
    bit                    query_set [MAX_DIMS];
    logic [DIMS_CFG_W-1:0] dims_reg = 5'd16;
    logic [NVEC_CFG_W-1:0] nvec_reg = 9'd256;
    logic [K_CFG_W-1:0]    k_reg    = 4'd8;
    bfkn_out_t             neighbours_due [$];
    int                    errors = 0;

    // Saturate the raw registers into the ranges the block honors.
    function int used_dims();
      if (dims_reg == 0) return 1;
      if (int'(dims_reg) > MAX_DIMS) return MAX_DIMS;
      return int'(dims_reg);
    endfunction

    function int used_vectors();
      if (int'(nvec_reg) > POOL_DEPTH) return POOL_DEPTH;
      return int'(nvec_reg);
    endfunction

    function int used_k();
      if (k_reg == 0) return 1;
      if (int'(k_reg) > MAX_NEIGHBOURS) return MAX_NEIGHBOURS;
      return int'(k_reg);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_DIMS_IN_USE:       dims_reg = data[DIMS_CFG_W-1:0];
        CFG_VECTORS_IN_USE:    nvec_reg = data[NVEC_CFG_W-1:0];
        CFG_NEIGHBOURS_IN_USE: k_reg    = data[K_CFG_W-1:0];
        default: ;
      endcase
    endfunction

    // Scan the pool against the query point and queue one word per rank.
    function void rank_pool();
      logic [DIST_W-1:0] best_dist [MAX_NEIGHBOURS];
      int                slot [MAX_NEIGHBOURS];
      bit                full [MAX_NEIGHBOURS];
      int                k, dims, p;
      longint            diff, acc;
      bfkn_out_t         r;
      k    = used_k();
      dims = used_dims();
      for (int j = 0; j < MAX_NEIGHBOURS; j++) begin
        best_dist[j] = DIST_MAX;
        slot[j] = 0;
        full[j] = 1'b0;
      end
      for (int i = 0; i < used_vectors(); i++) begin
        acc = 0;
        for (int j = 0; j < dims; j++) begin
          diff = longint'($signed(pool_mem[i][j])) - longint'($signed(query_pt[j]));
          acc += diff * diff;
        end
        // Skip past every filled slot at or below this distance: ties keep the earlier vector.
        p = 0;
        while (p < k && full[p] && best_dist[p] <= acc[DIST_W-1:0]) p++;
        if (p < k) begin
          for (int m = k - 1; m > p; m--) begin
            best_dist[m] = best_dist[m-1];
            slot[m] = slot[m-1];
            full[m] = full[m-1];
          end
          best_dist[p] = acc[DIST_W-1:0];
          slot[p] = i;
          full[p] = 1'b1;
        end
      end
      for (int j = 0; j < k; j++) begin
        r.rank            = RANK_W'(j);
        r.neighbour_index = full[j] ? VEC_W'(slot[j]) : '0;
        r.distance        = full[j] ? best_dist[j] : DIST_MAX;
        r.found           = full[j];
        r.last            = (j == k - 1);
        neighbours_due.push_back(r);
      end
    endfunction

    function void note_word(bfkn_in_t w);
      if (w.req_type == REQ_LOAD) begin
        if (int'(w.vector_index) < POOL_DEPTH && int'(w.component_index) < MAX_DIMS) begin
          pool_mem[w.vector_index][w.component_index] = w.component_value;
          pool_set[w.vector_index][w.component_index] = 1'b1;
        end
      end else if (int'(w.component_index) < MAX_DIMS) begin
        query_pt[w.component_index]  = w.component_value;
        query_set[w.component_index] = 1'b1;
        if (int'(w.component_index) == used_dims() - 1) rank_pool();
      end
    endfunction

    function void report(string field, logic [DIST_W-1:0] want, logic [DIST_W-1:0] got);
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_result(bfkn_out_t got);
      bfkn_out_t want;
      if (neighbours_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word: expected none, actual rank %0d index %0d dist %0d",
                 $time, got.rank, got.neighbour_index, got.distance);
      end else begin
        want = neighbours_due.pop_front();
        if (got.rank !== want.rank)
          report("rank", DIST_W'(want.rank), DIST_W'(got.rank));
        if (got.neighbour_index !== want.neighbour_index)
          report("neighbour_index", DIST_W'(want.neighbour_index),
                 DIST_W'(got.neighbour_index));
        if (got.distance !== want.distance) report("distance", want.distance, got.distance);
        if (got.found !== want.found)
          report("found", DIST_W'(want.found), DIST_W'(got.found));
        if (got.last !== want.last)
          report("last", DIST_W'(want.last), DIST_W'(got.last));
      end
    endfunction

    function int pending();
      return neighbours_due.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  bfkn_in_t              in_word;
  logic                  out_valid;
  logic                  out_ready;
  bfkn_out_t             out_word;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  knn_checker book;
  bit         idling;     // random gaps on both sides while set
  bit         hold_long;  // ask the receiver for one long hold-off
  int         quiet_cycles;

  brute_force_k_nearest_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic bfkn_in_t word_of(logic kind, int vec, int comp, logic [COMP_W-1:0] value);
    bfkn_in_t w;
    w.req_type        = kind;
    w.vector_index    = VEC_W'(vec);
    w.component_index = DIM_W'(comp);
    w.component_value = value;
    return w;
  endfunction

  // Mix the extremes, small values near zero (these make equal distances common)
  // and the full range.
  function automatic logic [COMP_W-1:0] rand_component();
    case ($urandom_range(0, 5))
      0: return COMP_MIN;
      1: return COMP_MAX;
      2, 3: return COMP_W'($urandom_range(0, 6)) - 16'd3;
      default: return COMP_W'($urandom);
    endcase
  endfunction

  // Offer one word and hold it until accepted. Valid stays high between
  // back-to-back words; a random gap lowers it first.
  task automatic send_word(input bfkn_in_t w);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_ready !== 1'b1);
    book.note_word(w);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    @(posedge clk);
    book.write_reg(idx, CFG_DATA_W'(value));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering words and wait for every expected result word.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (book.pending() != 0);
  endtask

  // Reconfigure only with the block idle: drain, let the pipe settle, then write.
  task automatic configure(input int unsigned dims, input int unsigned nvec,
                           input int unsigned k);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write(CFG_DIMS_IN_USE, dims);
    cfg_write(CFG_VECTORS_IN_USE, nvec);
    cfg_write(CFG_NEIGHBOURS_IN_USE, k);
  endtask

  // Fill every pool entry the next search reads; refresh some written ones too.
  task automatic load_pool();
    for (int i = 0; i < book.used_vectors(); i++)
      for (int j = 0; j < book.used_dims(); j++)
        if (!book.pool_set[i][j] || $urandom_range(0, 3) == 0)
          send_word(word_of(REQ_LOAD, i, j, rand_component()));
  endtask

  // One search: query components in random order (any never written are
  // included), some stray components above the range in use and some loads
  // mixed in, then the last component in use, which starts the scan.
  task automatic run_query();
    int picks [MAX_DIMS];
    int count, swap_at, held, d;
    d     = book.used_dims();
    count = 0;
    for (int j = 0; j < MAX_DIMS; j++) begin
      if (j < d - 1) begin
        if (!book.query_set[j] || $urandom_range(0, 3) != 0) begin
          picks[count] = j;
          count++;
        end
      end else if (j >= d && $urandom_range(0, 4) == 0) begin
        picks[count] = j;
        count++;
      end
    end
    for (int j = count - 1; j > 0; j--) begin
      swap_at       = $urandom_range(0, j);
      held          = picks[j];
      picks[j]      = picks[swap_at];
      picks[swap_at] = held;
    end
    for (int j = 0; j < count; j++) begin
      if ($urandom_range(0, 5) == 0)
        send_word(word_of(REQ_LOAD, $urandom_range(0, 255), $urandom_range(0, 15),
                          rand_component()));
      send_word(word_of(REQ_QUERY, $urandom_range(0, 255), picks[j], rand_component()));
    end
    send_word(word_of(REQ_QUERY, $urandom_range(0, 255), d - 1, rand_component()));
  endtask

  // Receiver: ready by default, short random stalls while idling is on, and one
  // long hold-off on request so the block fills and blocks its input.
  initial begin
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_long = 1'b0;
        out_ready <= 1'b1;
      end else if (idling && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Check every result word that moves.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready === 1'b1) book.check_result(out_word);
  end

  // Watchdog: count cycles in which no word moves on either channel.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready === 1'b1))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("brute_force_k_nearest_top verification failed");
    $finish;
  end

  initial begin
    book      = new;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    idling    = 1'b1;
    hold_long = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: two components, four vectors, eight ranks so half stay empty.
    configure(2, 4, 8);
    cfg_write(CFG_SPARE_INDEX, 9'h1FF);  // unmapped index: no effect
    send_word(word_of(REQ_LOAD, 0, 0, COMP_MIN));
    send_word(word_of(REQ_LOAD, 0, 1, COMP_MAX));
    send_word(word_of(REQ_LOAD, 1, 0, COMP_MAX));
    send_word(word_of(REQ_LOAD, 1, 1, COMP_MIN));
    for (int i = 2; i < 4; i++)
      for (int j = 0; j < 2; j++)
        send_word(word_of(REQ_LOAD, i, j, COMP_ZERO));  // two identical vectors tie
    send_word(word_of(REQ_LOAD, 255, 15, COMP_ONES));   // far corner of the pool
    send_word(word_of(REQ_QUERY, 0, 9, COMP_MAX));      // above the range in use: store only
    send_word(word_of(REQ_QUERY, 0, 0, COMP_MIN));      // not the last one: store only
    send_word(word_of(REQ_QUERY, 255, 1, COMP_MAX));    // exact hit on vector 0, widest distances
    send_word(word_of(REQ_QUERY, 0, 1, COMP_ZERO));     // search again on the kept component
    send_word(word_of(REQ_QUERY, 0, 0, COMP_ZERO));
    send_word(word_of(REQ_QUERY, 0, 1, COMP_ZERO));     // zero distance tie on vectors 2 and 3

    // Widest vectors, single rank.
    configure(16, 1, 1);
    load_pool();
    run_query();

    // Zero registers: one component, nothing scanned, rank count saturates to eight.
    configure(0, 0, 15);
    repeat (2) run_query();

    // Component count saturates to sixteen; one vector, three ranks.
    configure(31, 1, 3);
    load_pool();
    run_query();

    // Long receiver hold-off with the sender still pushing, then a full sender pause.
    configure(2, 6, 5);
    load_pool();
    hold_long = 1'b1;
    repeat (2) run_query();
    wait_drained();
    run_query();

    // Last stretch without gaps or stalls; rank count saturates.
    idling = 1'b0;
    configure(1, 12, 9);
    load_pool();
    repeat (3) run_query();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (book.errors == 0) begin
      $display("brute_force_k_nearest_top verification clean");
    end else begin
      $display("brute_force_k_nearest_top verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/bfkn_pkg.sv
src/bfkn_ram.sv
src/bfkn_dist.sv
src/bfkn_cell.sv
src/brute_force_k_nearest_top.sv
src/bfkn_chk.sv
tb/sv/brute_force_k_nearest_top_test.sv
